[rtl/mti_pkg.sv]
package mti_pkg;

	localparam int EDGE_TABLE_DEPTH   = 1024;
	localparam int INDEX_BITS         = 16;
	localparam int VERTEX_NUMBER_BITS = 20;

	localparam int ADDR_W  = $clog2(EDGE_TABLE_DEPTH);
	localparam int CNT_W   = ADDR_W + 1;
	localparam int KEY_W   = 2 * INDEX_BITS;
	localparam int ENTRY_W = KEY_W + VERTEX_NUMBER_BITS;

	// corner height plus offset, and differences of two of them
	localparam int HT_W  = 18;
	// coordinate span: signed index difference times grid step
	localparam int M_W   = INDEX_BITS + 17;
	// interpolation numerator
	localparam int N_W   = HT_W + M_W;
	// divider: 2|n|+|d| over 2|d|, also index over columns
	localparam int DIV_N = N_W + 1;
	localparam int DIV_D = 20;
	localparam int CO_W  = 33;
	localparam int SUM_W = CO_W + 2;

	typedef enum logic [2:0] {
		CFG_ISO_LEVEL     = 3'd0,
		CFG_HEIGHT_OFFSET = 3'd1,
		CFG_GRID_COLUMNS  = 3'd2,
		CFG_X_ORIGIN      = 3'd3,
		CFG_Y_ORIGIN      = 3'd4,
		CFG_GRID_STEP     = 3'd5
	} cfg_index_t;

	localparam logic [1:0] KIND_CONTINUE = 2'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK_REQ,
		ST_LOOK_WAIT,
		ST_DIVH_REQ,
		ST_DIVH_WAIT,
		ST_DIVO_REQ,
		ST_DIVO_WAIT,
		ST_MUL_A,
		ST_MUL_B,
		ST_ABS,
		ST_QDIV_REQ,
		ST_QDIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] corner_a_index;
		logic [INDEX_BITS-1:0] corner_b_index;
		logic [INDEX_BITS-1:0] corner_c_index;
		logic signed [15:0]    corner_a_height;
		logic signed [15:0]    corner_b_height;
		logic signed [15:0]    corner_c_height;
		logic [1:0]            start_kind;
	} item_t;

	typedef struct packed {
		logic [VERTEX_NUMBER_BITS-1:0] vertex_number;
		logic                          is_new;
		logic signed [15:0]            point_x;
		logic signed [15:0]            point_y;
		logic signed [15:0]            point_z;
		logic                          table_full;
		logic                          last;
	} result_t;

	typedef struct packed {
		logic             go;
		logic [KEY_W-1:0] key;
	} lookup_req_t;

	typedef struct packed {
		logic                          we;
		logic [KEY_W-1:0]              key;
		logic [VERTEX_NUMBER_BITS-1:0] vnum;
	} insert_t;

	typedef struct packed {
		logic                          done;
		logic                          found;
		logic                          full;
		logic [VERTEX_NUMBER_BITS-1:0] vnum;
	} lookup_resp_t;

endpackage

[rtl/mti_ram.sv]
module mti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[rtl/mti_div.sv]
module mti_div
	import mti_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_N-1:0] dividend,
	input  logic [DIV_D-1:0] divisor,
	output logic             done,
	output logic [DIV_N-1:0] quotient,
	output logic [DIV_D-1:0] remainder
);

	localparam int STEP_W = $clog2(DIV_N + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_N-1:0]  dq_q;
	logic [DIV_D-1:0]  rem_q;
	logic [DIV_D-1:0]  dvs_q;
	logic [DIV_D:0]    trial;
	logic [DIV_D:0]    diff;
	logic              ge;
	logic              last_step;

	// restoring division, one quotient bit per cycle
	assign trial     = {rem_q, dq_q[DIV_N-1]};
	assign ge        = trial >= {1'b0, dvs_q};
	assign diff      = trial - {1'b0, dvs_q};
	assign last_step = run_q && (step_q == STEP_W'(DIV_N - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= last_step;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[DIV_N-2:0], ge};
			rem_q <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

[rtl/mti_lookup.sv]
module mti_lookup
	import mti_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clear,
	input  lookup_req_t  req,
	input  insert_t      ins,
	output lookup_resp_t resp
);

	// entries are appended in order, so valid entries are exactly 0..fill-1
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               scan_q;
	logic               pend_s1;
	logic [KEY_W-1:0]   key_q;
	logic [ENTRY_W-1:0] rdata;
	logic               full;
	logic               ins_ok;
	logic               rd_en;
	logic               hit;
	logic               done;

	assign full   = fill_q == CNT_W'(EDGE_TABLE_DEPTH);
	assign ins_ok = ins.we && !full;
	assign rd_en  = scan_q && (ptr_q != fill_q);
	assign hit    = pend_s1 && (rdata[ENTRY_W-1 -: KEY_W] == key_q);
	assign done   = scan_q && (hit || (!pend_s1 && (ptr_q == fill_q)));

	mti_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (EDGE_TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (rd_en || ins_ok),
		.we    (ins_ok),
		.addr  (ins_ok ? fill_q[ADDR_W-1:0] : ptr_q[ADDR_W-1:0]),
		.wdata ({ins.key, ins.vnum}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ptr_q   <= '0;
			scan_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			if (clear) begin
				fill_q <= '0;
			end else if (ins_ok) begin
				fill_q <= fill_q + 1'b1;
			end
			if (req.go) begin
				scan_q  <= 1'b1;
				ptr_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (scan_q) begin
				if (done) begin
					scan_q  <= 1'b0;
					pend_s1 <= 1'b0;
				end else begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			key_q <= req.key;
		end
	end

	assign resp.done  = done;
	assign resp.found = hit;
	assign resp.full  = full;
	assign resp.vnum  = rdata[VERTEX_NUMBER_BITS-1:0];

endmodule

[rtl/marching_triangles_isoline.sv]
// Isoline extraction, one mesh triangle per transfer.
// Input: a triangle transfers when start is high and busy is low. The
// triangle carries three grid indices, three Q7.8 heights and a start code
// (new level empties the edge table, new frame also restarts numbering).
// Output: a triangle that is cut by the level gives two results, one per cut
// edge, each shown for one cycle with result_strobe high; the receiver
// cannot stall, so results leave as they are produced. Uncut triangles give
// nothing, busy stays low and the next triangle may transfer in the next cycle.
// Processing: each edge is first searched in the edge table, one entry per
// cycle. A reused edge then emits at once. A new edge runs four passes
// through the shared 52-step divider (two index splits into row/column, the
// x and y interpolation), with the multiply and setup states MUL_A, MUL_B
// and ABS before each interpolation pass, then emits. A triangle holds busy
// until both edges have emitted, so the next triangle cannot transfer
// before then; the divider and the linear scan set the pace.
// Configuration writes are registered and must be made only while idle; the
// block does not enforce it. Reset: registers take their defaults, the edge
// table is empty and the vertex counter is zero; no clearing pass is needed.
module marching_triangles_isoline
	import mti_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        result_strobe,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic signed [15:0] iso_level_q;
	logic [7:0]         height_offset_q;
	logic [15:0]        grid_columns_q;
	logic signed [15:0] x_origin_q;
	logic signed [15:0] y_origin_q;
	logic [14:0]        grid_step_q;

	state_t state_q, state_d;

	// triangle, apex first
	logic [INDEX_BITS-1:0]    ap_idx_q, o1_idx_q, o2_idx_q;
	logic signed [HT_W-2:0]   ap_t_q, o1_t_q, o2_t_q;
	logic                     edge_sel_q;
	logic                     coord_sel_q;
	logic [VERTEX_NUMBER_BITS-1:0] counter_q;

	// lookup outcome
	logic                          found_q;
	logic                          full_q;
	logic [VERTEX_NUMBER_BITS-1:0] vnum_q;

	// datapath
	logic [INDEX_BITS-1:0]    row_h_q, col_h_q, row_o_q, col_o_q;
	logic signed [M_W-1:0]    m_q;
	logic signed [N_W-1:0]    n_q;
	logic [DIV_N-1:0]         dividend_q;
	logic                     neg_q;
	logic signed [CO_W-1:0]   co_q;
	logic signed [15:0]       px_q, py_q;

	// accept-cycle classification
	logic signed [HT_W-2:0] t_a, t_b, t_c, v_ext;
	logic [2:0]             mask, emask;
	logic                   cut;
	logic                   accept;

	// per-edge values
	logic [INDEX_BITS-1:0]  oth_idx;
	logic signed [HT_W-2:0] oth_t;
	logic signed [HT_W-1:0] f_val, d_val, d_neg;
	logic [HT_W-2:0]        d_abs;
	logic [INDEX_BITS-1:0]  key_lo, key_hi;
	logic [15:0]            cols_eff;

	logic signed [INDEX_BITS:0] idx_diff;
	logic signed [M_W-1:0]      m_d;
	logic signed [N_W-1:0]      n_d;
	logic [N_W-1:0]             n_abs;
	logic [INDEX_BITS+14:0]     base_prod;
	logic signed [15:0]         origin_sel;
	logic [M_W-1:0]             q_mag;
	logic signed [SUM_W-1:0]    q_signed, coord_sum;
	logic signed [15:0]         coord_sat;

	// control to units
	logic             div_go;
	logic [DIV_N-1:0] div_dividend;
	logic [DIV_D-1:0] div_divisor;
	logic             div_done;
	logic [DIV_N-1:0] div_quo;
	logic [DIV_D-1:0] div_rem;
	lookup_req_t      look_req;
	insert_t          ins;
	lookup_resp_t     look_resp;
	logic             clear_table;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_level_q     <= -16'sd768;
			height_offset_q <= 8'd3;
			grid_columns_q  <= 16'd200;
			x_origin_q      <= -16'sd2560;
			y_origin_q      <= -16'sd2560;
			grid_step_q     <= 15'd26;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ISO_LEVEL:     iso_level_q     <= cfg_data;
				CFG_HEIGHT_OFFSET: height_offset_q <= cfg_data[7:0];
				CFG_GRID_COLUMNS:  grid_columns_q  <= cfg_data;
				CFG_X_ORIGIN:      x_origin_q      <= cfg_data;
				CFG_Y_ORIGIN:      y_origin_q      <= cfg_data;
				CFG_GRID_STEP:     grid_step_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cols_eff = (grid_columns_q == 16'd0) ? 16'd1 : grid_columns_q;

	// ---------------------------------------------------------------
	// classification, done in the transfer cycle
	// ---------------------------------------------------------------
	assign v_ext = {iso_level_q[15], iso_level_q};
	assign t_a   = {item.corner_a_height[15], item.corner_a_height} + {9'd0, height_offset_q};
	assign t_b   = {item.corner_b_height[15], item.corner_b_height} + {9'd0, height_offset_q};
	assign t_c   = {item.corner_c_height[15], item.corner_c_height} + {9'd0, height_offset_q};
	assign mask  = {t_c > v_ext, t_b > v_ext, t_a > v_ext};
	assign cut   = (mask != 3'b000) && (mask != 3'b111);
	// two corners above: the lone corner below is the apex
	assign emask = (mask == 3'b011 || mask == 3'b101 || mask == 3'b110) ? ~mask : mask;
	assign accept = start && (state_q == ST_IDLE);

	// ---------------------------------------------------------------
	// current edge
	// ---------------------------------------------------------------
	assign oth_idx = edge_sel_q ? o2_idx_q : o1_idx_q;
	assign oth_t   = edge_sel_q ? o2_t_q : o1_t_q;
	assign f_val   = {v_ext[HT_W-2], v_ext} - {oth_t[HT_W-2], oth_t};
	assign d_val   = {ap_t_q[HT_W-2], ap_t_q} - {oth_t[HT_W-2], oth_t};
	assign d_neg   = -d_val;
	assign d_abs   = d_val[HT_W-1] ? d_neg[HT_W-2:0] : d_val[HT_W-2:0];
	assign key_lo  = (ap_idx_q < oth_idx) ? ap_idx_q : oth_idx;
	assign key_hi  = (ap_idx_q < oth_idx) ? oth_idx : ap_idx_q;

	// span of the coordinate along the edge, in Q7.8
	assign idx_diff = coord_sel_q ?
		($signed({1'b0, col_h_q}) - $signed({1'b0, col_o_q})) :
		($signed({1'b0, row_h_q}) - $signed({1'b0, row_o_q}));
	assign m_d = idx_diff * $signed({1'b0, grid_step_q});
	assign n_d = f_val * m_q;

	assign n_abs      = n_q[N_W-1] ? N_W'(-n_q) : N_W'(n_q);
	assign base_prod  = (coord_sel_q ? col_o_q : row_o_q) * grid_step_q;
	assign origin_sel = coord_sel_q ? y_origin_q : x_origin_q;

	// rounded quotient, sign applied, added to the far corner's coordinate
	assign q_mag     = div_quo[M_W-1:0];
	assign q_signed  = neg_q ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
	assign coord_sum = {{2{co_q[CO_W-1]}}, co_q} + q_signed;
	always_comb begin
		if (coord_sum > SUM_W'(32767)) begin
			coord_sat = 16'sd32767;
		end else if (coord_sum < -SUM_W'(32768)) begin
			coord_sat = -16'sd32768;
		end else begin
			coord_sat = coord_sum[15:0];
		end
	end

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (start && cut) state_d = ST_LOOK_REQ;
			ST_LOOK_REQ:  state_d = ST_LOOK_WAIT;
			ST_LOOK_WAIT: begin
				if (look_resp.done) begin
					state_d = look_resp.found ? ST_EMIT : ST_DIVH_REQ;
				end
			end
			ST_DIVH_REQ:  state_d = ST_DIVH_WAIT;
			ST_DIVH_WAIT: if (div_done) state_d = ST_DIVO_REQ;
			ST_DIVO_REQ:  state_d = ST_DIVO_WAIT;
			ST_DIVO_WAIT: if (div_done) state_d = ST_MUL_A;
			ST_MUL_A:     state_d = ST_MUL_B;
			ST_MUL_B:     state_d = ST_ABS;
			ST_ABS:       state_d = ST_QDIV_REQ;
			ST_QDIV_REQ:  state_d = ST_QDIV_WAIT;
			ST_QDIV_WAIT: begin
				if (div_done) begin
					state_d = coord_sel_q ? ST_EMIT : ST_MUL_A;
				end
			end
			ST_EMIT:      state_d = edge_sel_q ? ST_IDLE : ST_LOOK_REQ;
			default:      state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// outputs and unit controls
	// ---------------------------------------------------------------
	always_comb begin
		busy          = state_q != ST_IDLE;
		result_strobe = state_q == ST_EMIT;
		look_req.go   = state_q == ST_LOOK_REQ;
		look_req.key  = {key_lo, key_hi};
		ins.we        = (state_q == ST_EMIT) && !found_q;
		ins.key       = {key_lo, key_hi};
		ins.vnum      = counter_q;
		clear_table   = accept && (item.start_kind != KIND_CONTINUE);
		div_go        = (state_q == ST_DIVH_REQ) || (state_q == ST_DIVO_REQ) ||
		                (state_q == ST_QDIV_REQ);
		unique case (state_q)
			ST_DIVH_REQ: begin
				div_dividend = DIV_N'(ap_idx_q);
				div_divisor  = DIV_D'(cols_eff);
			end
			ST_DIVO_REQ: begin
				div_dividend = DIV_N'(oth_idx);
				div_divisor  = DIV_D'(cols_eff);
			end
			default: begin
				div_dividend = dividend_q;
				div_divisor  = DIV_D'({d_abs, 1'b0});
			end
		endcase

		result.vertex_number = found_q ? vnum_q : counter_q;
		result.is_new        = !found_q;
		result.point_x       = found_q ? 16'sd0 : px_q;
		result.point_y       = found_q ? 16'sd0 : py_q;
		result.point_z       = found_q ? 16'sd0 : iso_level_q;
		result.table_full    = !found_q && full_q;
		result.last          = edge_sel_q;
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			edge_sel_q  <= 1'b0;
			coord_sel_q <= 1'b0;
			counter_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				edge_sel_q <= 1'b0;
				if (item.start_kind[1]) begin
					counter_q <= '0;
				end
			end
			if (state_q == ST_LOOK_WAIT) begin
				coord_sel_q <= 1'b0;
			end
			if (state_q == ST_QDIV_WAIT && div_done) begin
				coord_sel_q <= 1'b1;
			end
			if (state_q == ST_EMIT) begin
				edge_sel_q <= 1'b1;
				if (!found_q) begin
					counter_q <= counter_q + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (emask)
				3'b001: begin
					ap_idx_q <= item.corner_a_index; ap_t_q <= t_a;
					o1_idx_q <= item.corner_b_index; o1_t_q <= t_b;
					o2_idx_q <= item.corner_c_index; o2_t_q <= t_c;
				end
				3'b010: begin
					ap_idx_q <= item.corner_b_index; ap_t_q <= t_b;
					o1_idx_q <= item.corner_a_index; o1_t_q <= t_a;
					o2_idx_q <= item.corner_c_index; o2_t_q <= t_c;
				end
				default: begin
					ap_idx_q <= item.corner_c_index; ap_t_q <= t_c;
					o1_idx_q <= item.corner_b_index; o1_t_q <= t_b;
					o2_idx_q <= item.corner_a_index; o2_t_q <= t_a;
				end
			endcase
		end
		if (state_q == ST_LOOK_WAIT && look_resp.done) begin
			found_q <= look_resp.found;
			full_q  <= look_resp.full;
			vnum_q  <= look_resp.vnum;
		end
		if (state_q == ST_DIVH_WAIT && div_done) begin
			row_h_q <= div_quo[INDEX_BITS-1:0];
			col_h_q <= div_rem[INDEX_BITS-1:0];
		end
		if (state_q == ST_DIVO_WAIT && div_done) begin
			row_o_q <= div_quo[INDEX_BITS-1:0];
			col_o_q <= div_rem[INDEX_BITS-1:0];
		end
		if (state_q == ST_MUL_A) begin
			m_q <= m_d;
		end
		if (state_q == ST_MUL_B) begin
			n_q <= n_d;
		end
		if (state_q == ST_ABS) begin
			// round half away from zero: (2|n| + |d|) / (2|d|)
			dividend_q <= {n_abs, 1'b0} + DIV_N'(d_abs);
			neg_q      <= n_q[N_W-1] ^ d_val[HT_W-1];
			co_q       <= {{(CO_W-16){origin_sel[15]}}, origin_sel} +
			              $signed({2'b00, base_prod});
		end
		if (state_q == ST_QDIV_WAIT && div_done) begin
			if (coord_sel_q) begin
				py_q <= coord_sat;
			end else begin
				px_q <= coord_sat;
			end
		end
	end

	mti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	mti_lookup u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear_table),
		.req    (look_req),
		.ins    (ins),
		.resp   (look_resp)
	);

endmodule
